[hdl/mdss_pkg.sv]
// Shared types, constants and the ID ROM of the multidrop serial slave.
// No dependencies; used by mdss_addr_fold and multidrop_serial_slave_unit.
`timescale 1ns / 1ps

package mdss_pkg;

  // Default sizes of the byte store, its wrap point and the ID ROM.
  localparam int unsigned STORE_DEPTH_DEF = 1024;
  localparam int unsigned MEM_END_DEF     = 1023;
  localparam int unsigned ID_LEN_DEF      = 25;

  // Width of the buffer address (high byte and low byte).
  localparam int unsigned PTR_W = 16;

  // Command codes received while selected.
  localparam logic [7:0] CMD_DESELECT = 8'hFF;
  localparam logic [7:0] CMD_ID_START = 8'hFE;
  localparam logic [7:0] CMD_ID_NEXT  = 8'hFD;
  localparam logic [7:0] CMD_ADDR_SET = 8'hFC;
  localparam logic [7:0] CMD_BOOT_IN  = 8'hFB;
  localparam logic [7:0] CMD_BOOT_OUT = 8'hFA;
  localparam logic [7:0] CMD_BUF_READ = 8'h01;
  localparam logic [7:0] CMD_BUF_WRITE = 8'h02;

  // Reply codes.
  localparam logic [7:0] REPLY_ACK = 8'hA5;
  localparam logic [7:0] REPLY_NAK = 8'h00;

  // Handshake between the sequencer and the address fold pipeline.
  typedef struct packed {
    logic busy;
    logic ptr_load;
    logic idx_load;
  } fold_ctl_t;

  // Identification ROM; entries past the programmed length read as zero.
  function automatic logic [7:0] id_rom_byte(input logic [4:0] addr);
    logic [7:0] b;
    unique case (addr)
      5'd0:  b = 8'h10;
      5'd1:  b = 8'h00;
      5'd2:  b = 8'h1d;
      5'd3:  b = 8'h01;
      5'd4:  b = 8'h03;
      5'd5:  b = 8'h0a;
      5'd6:  b = 8'h41;
      5'd7:  b = 8'h56;
      5'd8:  b = 8'h52;
      5'd9:  b = 8'h2d;
      5'd10: b = 8'h41;
      5'd11: b = 8'h20;
      5'd12: b = 8'h42;
      5'd13: b = 8'h4f;
      5'd14: b = 8'h4f;
      5'd15: b = 8'h54;
      5'd16: b = 8'h08;
      5'd17: b = 8'h54;
      5'd18: b = 8'h68;
      5'd19: b = 8'h6f;
      5'd20: b = 8'h6d;
      5'd21: b = 8'h70;
      5'd22: b = 8'h73;
      5'd23: b = 8'h6f;
      5'd24: b = 8'h6e;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[hdl/mdss_addr_fold.sv]
// Address fold pipeline: reduces a raw 16-bit buffer address by the wrap point
// and derives the store index from it. Depends on mdss_pkg.
`timescale 1ns / 1ps

module mdss_addr_fold #(
  parameter int unsigned STORE_DEPTH = mdss_pkg::STORE_DEPTH_DEF,
  parameter int unsigned MEM_END     = mdss_pkg::MEM_END_DEF,
  localparam int unsigned IDX_W      = $clog2(STORE_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mdss_pkg::PTR_W-1:0]    addr_raw,
  output mdss_pkg::fold_ctl_t           ctl,
  output logic [mdss_pkg::PTR_W-1:0]    ptr,
  output logic [IDX_W-1:0]              idx
);

  // Reciprocals scaled by 2^32; exact quotients for every 16-bit dividend.
  localparam logic [31:0] END_RECIP   = 32'(((64'd1 << 32) / MEM_END) + 64'd1);
  localparam logic [31:0] DEPTH_RECIP = 32'(((64'd1 << 32) / STORE_DEPTH) + 64'd1);

  logic                       v1, v2, v3;
  logic [mdss_pkg::PTR_W-1:0] a1, x1, q1;
  logic                       need1;
  logic [mdss_pkg::PTR_W-1:0] ptr2, ptr3, q2;

  logic [mdss_pkg::PTR_W-1:0] x0;
  logic [47:0]                prod1, prod2;
  logic [31:0]                back1, back2, diff2;
  logic [mdss_pkg::PTR_W-1:0] r1;

  // First stage: quotient of (address - 1) by the wrap point.
  assign x0    = addr_raw - mdss_pkg::PTR_W'(1);
  assign prod1 = 48'(x0) * 48'(END_RECIP);

  // Second stage: past the wrap point, remainder plus one is the folded pointer.
  assign back1 = 32'(q1) * 32'(MEM_END);
  assign r1    = x1 - back1[mdss_pkg::PTR_W-1:0];
  assign ptr   = need1 ? (r1 + mdss_pkg::PTR_W'(1)) : a1;

  // Third and fourth stages: pointer modulo the store depth.
  assign prod2 = 48'(ptr2) * 48'(DEPTH_RECIP);
  assign back2 = 32'(q2) * 32'(STORE_DEPTH);
  assign diff2 = 32'(ptr3) - back2;
  assign idx   = diff2[IDX_W-1:0];

  assign ctl.busy     = v1 | v2 | v3;
  assign ctl.ptr_load = v1;
  assign ctl.idx_load = v3;

  // Pipeline registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
    a1    <= addr_raw;
    x1    <= x0;
    q1    <= prod1[47:32];
    need1 <= 32'(addr_raw) > MEM_END;
    ptr2  <= ptr;
    ptr3  <= ptr2;
    q2    <= prod2[47:32];
  end

  // The folded pointer never passes the wrap point.
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ctl.ptr_load |-> (32'(ptr) <= MEM_END))
    else $error("folded pointer beyond wrap point");

  // The index fits the store.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    ctl.idx_load |-> (32'(diff2) < STORE_DEPTH))
    else $error("store index out of range");

  // A new fold never starts while one is in flight.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    start |-> !ctl.busy)
    else $error("address fold restarted while busy");

endmodule

[hdl/multidrop_serial_slave_unit.sv]
// Top level of the multidrop serial slave: input register, command sequencer,
// byte store and result register. Depends on mdss_pkg and mdss_addr_fold.
`timescale 1ns / 1ps

// One received 9-bit word is taken per clock while no stalled reply waits. Its reply, if it
// has one, comes out of the result register in the cycle after the word is accepted. Because
// of that register, the next word can enter while the reply is presented. The one other
// exception to one word a cycle is the start of a buffer transfer: the address fold pipeline
// must produce the pointer and store index from the low address byte, so a first data beat
// that follows the count beat closely is held until the fold is no longer busy.
// The byte store is not cleared after reset; a read of a location that was
// never written returns arbitrary data. Writing cfg_wdata with cfg_wen set through the
// configuration port loads the slave address at once.
module multidrop_serial_slave_unit #(
  parameter int unsigned STORE_DEPTH = mdss_pkg::STORE_DEPTH_DEF,
  parameter int unsigned MEM_END     = mdss_pkg::MEM_END_DEF,
  parameter int unsigned ID_LEN      = mdss_pkg::ID_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic [7:0] cfg_wdata,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [8:0] rx_word,
  output logic       tx_valid,
  input  logic       tx_stall,
  output logic [7:0] tx_word,
  output logic       store_commit,
  output logic       address_saved,
  output logic [7:0] saved_address,
  output logic       leave_boot
);

  localparam int unsigned IDX_W = $clog2(STORE_DEPTH);
  localparam int unsigned PTR_W = mdss_pkg::PTR_W;

  typedef enum logic [3:0] {
    PH_UNSEL, PH_SEL, PH_ASET1, PH_ASET2, PH_HI, PH_LO, PH_CNT, PH_DATA, PH_HALT
  } phase_t;

  // Sequencer state.
  phase_t           phase, phase_next;
  logic             is_write, is_write_next;
  logic [7:0]       device_address, device_address_next;
  logic [4:0]       id_pointer, id_pointer_next;
  logic [7:0]       high_byte, high_byte_next;
  logic [PTR_W-1:0] store_pointer;
  logic [IDX_W-1:0] store_index;
  logic [7:0]       bytes_left, bytes_left_next;
  logic [7:0]       pending_address, pending_address_next;

  // Input register.
  logic       in_valid;
  logic [8:0] in_word;

  // Per-beat decode results.
  logic       take, hold;
  logic       emit;
  logic [7:0] tx_next;
  logic       commit_next, saved_next, leave_next;
  logic       mem_we, fold_start, advance;
  logic [7:0] d;
  logic       is_addr;
  logic [7:0] bytes_dec;

  // Store and its read port.
  logic [7:0]       byte_store [STORE_DEPTH];
  logic [7:0]       rd_data;
  logic [IDX_W-1:0] idx_adv, rd_idx;
  logic [PTR_W-1:0] ptr_adv;

  // Address fold pipeline.
  mdss_pkg::fold_ctl_t fold_ctl;
  logic [PTR_W-1:0]    fold_ptr;
  logic [IDX_W-1:0]    fold_idx;

  mdss_addr_fold #(
    .STORE_DEPTH(STORE_DEPTH),
    .MEM_END    (MEM_END)
  ) u_fold (
    .clk     (clk),
    .rst     (rst),
    .start   (fold_start),
    .addr_raw({high_byte, d}),
    .ctl     (fold_ctl),
    .ptr     (fold_ptr),
    .idx     (fold_idx)
  );

  // Handshake: a data beat waits for the fold pipeline to settle.
  assign hold     = (phase == PH_DATA) && fold_ctl.busy;
  assign take     = in_valid && !hold && (!tx_valid || !tx_stall);
  assign rx_stall = in_valid && !take;

  assign d         = in_word[7:0];
  assign is_addr   = in_word[8];
  assign bytes_dec = bytes_left - 8'd1;

  // Pointer and index step, wrapping at the end of the buffer.
  always_comb begin
    if (32'(store_pointer) >= MEM_END) begin
      ptr_adv = '0;
      idx_adv = '0;
    end else begin
      ptr_adv = store_pointer + PTR_W'(1);
      idx_adv = (32'(store_index) == STORE_DEPTH - 1) ? '0 : store_index + IDX_W'(1);
    end
  end

  always_comb begin
    if (fold_ctl.idx_load) begin
      rd_idx = fold_idx;
    end else if (advance) begin
      rd_idx = idx_adv;
    end else begin
      rd_idx = store_index;
    end
  end

  // Command decode for the beat in the input register.
  always_comb begin
    phase_next           = phase;
    is_write_next        = is_write;
    device_address_next  = device_address;
    id_pointer_next      = id_pointer;
    high_byte_next       = high_byte;
    bytes_left_next      = bytes_left;
    pending_address_next = pending_address;
    emit        = 1'b0;
    tx_next     = mdss_pkg::REPLY_NAK;
    commit_next = 1'b0;
    saved_next  = 1'b0;
    leave_next  = 1'b0;
    mem_we      = 1'b0;
    fold_start  = 1'b0;
    advance     = 1'b0;
    if (take) begin
      priority if (phase == PH_HALT) begin
        emit = 1'b0;
      end else if (phase == PH_UNSEL) begin
        if (is_addr && d == device_address) begin
          phase_next = PH_SEL;
          emit       = 1'b1;
          tx_next    = mdss_pkg::REPLY_ACK;
        end
      end else if (is_addr) begin
        // An address word aborts any command in progress.
        if (d == device_address) begin
          phase_next = PH_SEL;
          emit       = 1'b1;
          tx_next    = mdss_pkg::REPLY_ACK;
        end else begin
          phase_next = PH_UNSEL;
        end
      end else begin
        unique case (phase)
          PH_SEL: begin
            unique case (d)
              mdss_pkg::CMD_DESELECT: begin
                phase_next = PH_UNSEL;
                emit       = 1'b1;
                tx_next    = mdss_pkg::REPLY_NAK;
              end
              mdss_pkg::CMD_ID_START: begin
                id_pointer_next = '0;
                emit            = 1'b1;
                tx_next         = 8'(ID_LEN);
              end
              mdss_pkg::CMD_ID_NEXT: begin
                emit = 1'b1;
                if (32'(id_pointer) < ID_LEN) begin
                  tx_next         = mdss_pkg::id_rom_byte(id_pointer);
                  id_pointer_next = id_pointer + 5'd1;
                end else begin
                  tx_next = mdss_pkg::REPLY_NAK;
                end
              end
              mdss_pkg::CMD_ADDR_SET: begin
                phase_next = PH_ASET1;
                emit       = 1'b1;
                tx_next    = device_address;
              end
              mdss_pkg::CMD_BOOT_IN: begin
                emit    = 1'b1;
                tx_next = mdss_pkg::REPLY_ACK;
              end
              mdss_pkg::CMD_BOOT_OUT: begin
                phase_next = PH_HALT;
                emit       = 1'b1;
                tx_next    = mdss_pkg::REPLY_ACK;
                leave_next = 1'b1;
              end
              mdss_pkg::CMD_BUF_READ, mdss_pkg::CMD_BUF_WRITE: begin
                is_write_next = (d == mdss_pkg::CMD_BUF_WRITE);
                phase_next    = PH_HI;
                emit          = 1'b1;
                tx_next       = mdss_pkg::REPLY_ACK;
              end
              default: begin
                emit = 1'b0;
              end
            endcase
          end
          PH_ASET1: begin
            pending_address_next = d;
            phase_next           = PH_ASET2;
            emit                 = 1'b1;
            tx_next              = d;
          end
          PH_ASET2: begin
            phase_next = PH_SEL;
            emit       = 1'b1;
            if (d == pending_address) begin
              device_address_next = d;
              saved_next          = 1'b1;
              tx_next             = mdss_pkg::REPLY_ACK;
            end else begin
              tx_next = mdss_pkg::REPLY_NAK;
            end
          end
          PH_HI: begin
            high_byte_next = d;
            phase_next     = PH_LO;
            emit           = 1'b1;
            tx_next        = d;
          end
          PH_LO: begin
            fold_start = 1'b1;
            phase_next = PH_CNT;
            emit       = 1'b1;
            tx_next    = d;
          end
          PH_CNT: begin
            bytes_left_next = d;
            emit            = 1'b1;
            tx_next         = d;
            if (d == 8'd0) begin
              phase_next  = PH_SEL;
              commit_next = is_write;
            end else begin
              phase_next = PH_DATA;
            end
          end
          PH_DATA: begin
            emit            = 1'b1;
            advance         = 1'b1;
            mem_we          = is_write;
            tx_next         = is_write ? d : rd_data;
            bytes_left_next = bytes_dec;
            if (bytes_dec == 8'd0) begin
              phase_next  = PH_SEL;
              commit_next = is_write;
            end
          end
          default: begin
            phase_next = PH_UNSEL;
          end
        endcase
      end
    end
  end

  // Byte store with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      byte_store[store_index] <= d;
    end
    rd_data <= byte_store[rd_idx];
  end

  // State, input register and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_UNSEL;
      is_write        <= 1'b0;
      device_address  <= 8'd0;
      id_pointer      <= '0;
      high_byte       <= 8'd0;
      store_pointer   <= '0;
      store_index     <= '0;
      bytes_left      <= 8'd0;
      pending_address <= 8'd0;
      in_valid        <= 1'b0;
      tx_valid        <= 1'b0;
    end else begin
      phase           <= phase_next;
      is_write        <= is_write_next;
      id_pointer      <= id_pointer_next;
      high_byte       <= high_byte_next;
      bytes_left      <= bytes_left_next;
      pending_address <= pending_address_next;
      if (cfg_wen) begin
        device_address <= cfg_wdata;
      end else begin
        device_address <= device_address_next;
      end
      if (fold_ctl.ptr_load) begin
        store_pointer <= fold_ptr;
      end else if (advance) begin
        store_pointer <= ptr_adv;
      end
      if (fold_ctl.idx_load) begin
        store_index <= fold_idx;
      end else if (advance) begin
        store_index <= idx_adv;
      end
      if (!rx_stall) begin
        in_valid <= rx_valid;
      end
      if (take) begin
        tx_valid <= emit;
      end else if (!tx_stall) begin
        tx_valid <= 1'b0;
      end
    end
    if (!rx_stall) begin
      in_word <= rx_word;
    end
    if (take) begin
      tx_word       <= tx_next;
      store_commit  <= commit_next;
      address_saved <= saved_next;
      saved_address <= device_address_next;
      leave_boot    <= leave_next;
    end
  end

  // A data beat is never processed before its pointer is ready.
  a_data_after_fold: assert property (@(posedge clk) disable iff (rst)
    (take && phase == PH_DATA) |-> !fold_ctl.busy)
    else $error("data beat processed during address fold");

  // A boot exit reply leaves the sequencer halted.
  a_halt_on_exit: assert property (@(posedge clk) disable iff (rst)
    (tx_valid && leave_boot) |-> (phase == PH_HALT))
    else $error("boot exit reply without halt");

  // Outside a fold the pointer stays within the buffer.
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    !fold_ctl.busy |-> (32'(store_pointer) <= MEM_END))
    else $error("store pointer beyond wrap point");

endmodule

[tb/multidrop_serial_slave_unit_tb.sv]
// Self-checking testbench for multidrop_serial_slave_unit: random and directed word traffic,
// with a word-level predictor of the slave protocol and a scoreboard of reply beats.
// Depends on mdss_pkg (command and reply codes, default sizes) and the unit itself.
`timescale 1ns / 1ps

module multidrop_serial_slave_unit_tb;

  localparam int unsigned STORE_SIZE = mdss_pkg::STORE_DEPTH_DEF;
  localparam int unsigned WRAP_END = mdss_pkg::MEM_END_DEF;
  localparam int unsigned ID_BYTES = mdss_pkg::ID_LEN_DEF;
  localparam logic [7:0] ID_COUNT = 8'(mdss_pkg::ID_LEN_DEF);
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 400;

  // Expected contents of the identification ROM.
  localparam logic [0:24][7:0] ID_IMAGE = {
    8'h10, 8'h00, 8'h1d, 8'h01, 8'h03, 8'h0a, 8'h41, 8'h56, 8'h52, 8'h2d, 8'h41, 8'h20,
    8'h42, 8'h4f, 8'h4f, 8'h54, 8'h08, 8'h54, 8'h68, 8'h6f, 8'h6d, 8'h70, 8'h73, 8'h6f,
    8'h6e
  };

  // Directed opening traffic, sent with the slave address set to 0xFF.
  localparam int DIRECTED_LEN = 31;
  localparam logic [0:DIRECTED_LEN-1][8:0] DIRECTED_WORDS = {
    9'h0FE, 9'h100,                  // ignored while unselected
    9'h1FF, 9'h0FE, 9'h0FD, 9'h0FB,  // select, ID start, ID next, boot enter
    9'h0FC, 9'h000, 9'h000,          // move the slave to address zero
    9'h100,                          // select at the new address
    9'h002, 9'h0FF, 9'h0FF, 9'h003,  // write three bytes at address 0xFFFF
    9'h000, 9'h0FF, 9'h080,
    9'h001, 9'h0FF, 9'h0FF, 9'h002,  // read two of them back
    9'h0AA, 9'h055,
    9'h002, 9'h000, 9'h000, 9'h000,  // write with zero count
    9'h002, 9'h011, 9'h100,          // address word aborts a write
    9'h0FF                           // deselect
  };

  typedef enum logic [3:0] {
    PH_IDLE, PH_CMD, PH_NEWADDR, PH_CONFIRM, PH_ADDR_HI, PH_ADDR_LO, PH_COUNT, PH_DATA,
    PH_HALTED
  } slave_phase_t;

  typedef struct packed {
    logic [7:0] tx;
    logic       commit;
    logic       saved;
    logic [7:0] addr;
    logic       leave;
  } reply_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wen = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [8:0] rx_word = '0;
  logic       tx_valid;
  logic       tx_stall = 1'b0;
  logic [7:0] tx_word;
  logic       store_commit;
  logic       address_saved;
  logic [7:0] saved_address;
  logic       leave_boot;

  // Predicted slave state.
  slave_phase_t slave_phase = PH_IDLE;
  logic [7:0]   dev_addr = '0;
  logic [7:0]   new_addr_hold = '0;
  logic [7:0]   hi_byte = '0;
  logic [7:0]   bytes_left = '0;
  logic [4:0]   id_ptr = '0;
  logic [15:0]  store_ptr = '0;
  logic         write_op = 1'b0;
  logic [7:0]   store_mem [0:STORE_SIZE-1];
  bit           store_written [0:STORE_SIZE-1];

  reply_t     reply_q[$];
  logic [8:0] word_q[$];
  logic [8:0] body_q[$];
  int         words_queued = 0;
  int         words_taken = 0;
  int         fail_count = 0;

  // Sender burst shaping and receiver stall pattern.
  int         burst_left = 1;
  int         gap_left = 0;
  int         hold_left = 0;
  int         mode_left = 0;
  int         stall_mode = 0;
  logic [7:0] stall_tick = '0;
  bit         hold_req = 1'b0;
  bit         hold_done = 1'b0;

  multidrop_serial_slave_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .rx_valid      (rx_valid),
    .rx_stall      (rx_stall),
    .rx_word       (rx_word),
    .tx_valid      (tx_valid),
    .tx_stall      (tx_stall),
    .tx_word       (tx_word),
    .store_commit  (store_commit),
    .address_saved (address_saved),
    .saved_address (saved_address),
    .leave_boot    (leave_boot)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Buffer address as the slave folds it into the range 0..WRAP_END.
  function automatic logic [15:0] fold_addr(input logic [7:0] hi, input logic [7:0] lo);
    int unsigned a;
    a = 32'({hi, lo});
    if (a > WRAP_END) a = ((a - 1) % WRAP_END) + 1;
    return a[15:0];
  endfunction

  function automatic logic [15:0] next_ptr(input logic [15:0] p);
    return (p >= WRAP_END) ? 16'd0 : p + 16'd1;
  endfunction

  task automatic push_reply(input logic [7:0] tx, input logic commit, input logic saved,
                            input logic leave);
    reply_t r;
    r.tx = tx;
    r.commit = commit;
    r.saved = saved;
    r.addr = dev_addr;
    r.leave = leave;
    reply_q.push_back(r);
  endtask

  // Advances the predicted slave by one received word and queues its reply, if any.
  task automatic slave_model_step(input logic [8:0] w);
    logic [7:0] d;
    logic [7:0] tx;
    int unsigned idx;
    d = w[7:0];
    if (slave_phase == PH_HALTED) return;
    // An address word selects or deselects from any phase, aborting a command.
    if (w[8]) begin
      if (d == dev_addr) begin
        slave_phase = PH_CMD;
        push_reply(mdss_pkg::REPLY_ACK, 1'b0, 1'b0, 1'b0);
      end else begin
        slave_phase = PH_IDLE;
      end
      return;
    end
    case (slave_phase)
      PH_IDLE: ;
      PH_CMD: begin
        case (d)
          mdss_pkg::CMD_DESELECT: begin
            slave_phase = PH_IDLE;
            push_reply(mdss_pkg::REPLY_NAK, 1'b0, 1'b0, 1'b0);
          end
          mdss_pkg::CMD_ID_START: begin
            id_ptr = '0;
            push_reply(ID_COUNT, 1'b0, 1'b0, 1'b0);
          end
          mdss_pkg::CMD_ID_NEXT: begin
            // Past the end of the ROM the pointer stays put and zero comes back.
            if (id_ptr < ID_BYTES) begin
              tx = ID_IMAGE[id_ptr];
              id_ptr = id_ptr + 5'd1;
            end else begin
              tx = '0;
            end
            push_reply(tx, 1'b0, 1'b0, 1'b0);
          end
          mdss_pkg::CMD_ADDR_SET: begin
            slave_phase = PH_NEWADDR;
            push_reply(dev_addr, 1'b0, 1'b0, 1'b0);
          end
          mdss_pkg::CMD_BOOT_IN: push_reply(mdss_pkg::REPLY_ACK, 1'b0, 1'b0, 1'b0);
          mdss_pkg::CMD_BOOT_OUT: begin
            slave_phase = PH_HALTED;
            push_reply(mdss_pkg::REPLY_ACK, 1'b0, 1'b0, 1'b1);
          end
          mdss_pkg::CMD_BUF_READ, mdss_pkg::CMD_BUF_WRITE: begin
            write_op = (d == mdss_pkg::CMD_BUF_WRITE);
            slave_phase = PH_ADDR_HI;
            push_reply(mdss_pkg::REPLY_ACK, 1'b0, 1'b0, 1'b0);
          end
          default: ;
        endcase
      end
      PH_NEWADDR: begin
        new_addr_hold = d;
        slave_phase = PH_CONFIRM;
        push_reply(d, 1'b0, 1'b0, 1'b0);
      end
      PH_CONFIRM: begin
        slave_phase = PH_CMD;
        if (d == new_addr_hold) begin
          dev_addr = d;
          push_reply(mdss_pkg::REPLY_ACK, 1'b0, 1'b1, 1'b0);
        end else begin
          push_reply(mdss_pkg::REPLY_NAK, 1'b0, 1'b0, 1'b0);
        end
      end
      PH_ADDR_HI: begin
        hi_byte = d;
        slave_phase = PH_ADDR_LO;
        push_reply(d, 1'b0, 1'b0, 1'b0);
      end
      PH_ADDR_LO: begin
        store_ptr = fold_addr(hi_byte, d);
        slave_phase = PH_COUNT;
        push_reply(d, 1'b0, 1'b0, 1'b0);
      end
      PH_COUNT: begin
        // A zero count ends the transfer at the count echo.
        bytes_left = d;
        if (d == 8'd0) begin
          slave_phase = PH_CMD;
          push_reply(d, write_op, 1'b0, 1'b0);
        end else begin
          slave_phase = PH_DATA;
          push_reply(d, 1'b0, 1'b0, 1'b0);
        end
      end
      PH_DATA: begin
        idx = store_ptr % STORE_SIZE;
        if (write_op) begin
          store_mem[idx] = d;
          store_written[idx] = 1'b1;
          tx = d;
        end else begin
          tx = store_mem[idx];
        end
        store_ptr = next_ptr(store_ptr);
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'd0) begin
          slave_phase = PH_CMD;
          push_reply(tx, write_op, 1'b0, 1'b0);
        end else begin
          push_reply(tx, 1'b0, 1'b0, 1'b0);
        end
      end
      default: slave_phase = PH_IDLE;
    endcase
  endtask

  // Sender: offers queued words in bursts, predicting each beat as it is taken.
  always @(posedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
      rx_word <= '0;
    end else begin
      if (rx_valid && !rx_stall) begin
        slave_model_step(rx_word);
        words_taken++;
      end
      if (!rx_valid || !rx_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          rx_valid <= 1'b0;
        end else if (word_q.size() != 0) begin
          rx_valid <= 1'b1;
          rx_word <= word_q.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(100, 300);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = $urandom_range(0, 6);
          end
        end else begin
          rx_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_reply();
    reply_t want;
    if (reply_q.size() == 0) begin
      $display("%0t: unexpected reply beat: expected none, actual tx_word %h", $time, tx_word);
      fail_count++;
      return;
    end
    want = reply_q.pop_front();
    compare_field("tx_word", want.tx, tx_word);
    compare_field("store_commit", 8'(want.commit), 8'(store_commit));
    compare_field("address_saved", 8'(want.saved), 8'(address_saved));
    compare_field("saved_address", want.addr, saved_address);
    compare_field("leave_boot", 8'(want.leave), 8'(leave_boot));
  endtask

  // Receiver: checks each reply beat and stalls on a changing pattern,
  // with one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      tx_stall <= 1'b0;
    end else begin
      if (tx_valid && !tx_stall) check_reply();
      stall_tick++;
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        tx_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: tx_stall <= 1'b0;
          1: tx_stall <= ($urandom_range(0, 3) == 0);
          2: tx_stall <= ($urandom_range(0, 3) != 0);
          default: tx_stall <= stall_tick[2];
        endcase
      end
    end
  end

  task automatic push_word(input logic [8:0] w);
    word_q.push_back(w);
    words_queued++;
  endtask

  // Waits until every queued word has been taken, so the predicted state is current.
  task automatic sync_to_model();
    while (words_taken != words_queued) @(posedge clk);
  endtask

  task automatic settle();
    sync_to_model();
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_address(input logic [7:0] value);
    settle();
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    dev_addr = value;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Pushes the command body, cut short and aborted by an address word when broken.
  task automatic emit_body(input bit broken);
    int stop;
    logic [7:0] r;
    stop = body_q.size();
    if (broken && stop > 1) stop = $urandom_range(1, stop - 1);
    for (int i = 0; i < stop; i++) push_word(body_q[i]);
    if (broken) begin
      r = 8'($urandom_range(0, 255));
      push_word({1'b1, $urandom_range(0, 1) ? dev_addr : r});
    end
    body_q.delete();
  endtask

  task automatic send_write(input int cnt, input bit broken);
    logic [15:0] a;
    logic [7:0] c;
    a = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) :
                               16'($urandom_range(0, WRAP_END));
    c = 8'(cnt);
    push_word({1'b1, dev_addr});
    body_q = {{1'b0, mdss_pkg::CMD_BUF_WRITE}, {1'b0, a[15:8]}, {1'b0, a[7:0]}, {1'b0, c}};
    repeat (cnt) body_q.push_back({1'b0, 8'($urandom_range(0, 255))});
    emit_body(broken);
  endtask

  // Reads only from runs of locations that already hold written data.
  task automatic send_read(input bit broken);
    int unsigned start;
    int unsigned run;
    int unsigned k;
    int unsigned cnt;
    logic [15:0] p;
    logic [15:0] a;
    logic [7:0] c;
    bit found;
    found = 1'b0;
    start = 0;
    for (int t = 0; t < 16 && !found; t++) begin
      start = $urandom_range(0, WRAP_END);
      found = store_written[start % STORE_SIZE];
    end
    if (found) begin
      run = 0;
      p = 16'(start);
      while (run < 255 && store_written[p % STORE_SIZE]) begin
        run++;
        p = next_ptr(p);
      end
      cnt = $urandom_range(1, (run > 16 && $urandom_range(0, 7) != 0) ? 16 : run);
      // Aliased addresses above the wrap point fold back to the same start.
      k = (start == 0) ? 0 : $urandom_range(0, (65535 - start) / WRAP_END);
      a = 16'(start + WRAP_END * k);
    end else begin
      cnt = 0;
      a = 16'($urandom_range(0, 65535));
    end
    c = 8'(cnt);
    push_word({1'b1, dev_addr});
    body_q = {{1'b0, mdss_pkg::CMD_BUF_READ}, {1'b0, a[15:8]}, {1'b0, a[7:0]}, {1'b0, c}};
    repeat (cnt) body_q.push_back({1'b0, 8'($urandom_range(0, 255))});
    emit_body(broken);
  endtask

  task automatic send_id(input bit broken);
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(26, 30) : $urandom_range(1, 8);
    push_word({1'b1, dev_addr});
    if ($urandom_range(0, 3) != 0) body_q.push_back({1'b0, mdss_pkg::CMD_ID_START});
    repeat (n) body_q.push_back({1'b0, mdss_pkg::CMD_ID_NEXT});
    emit_body(broken);
  endtask

  task automatic send_addr_set(input bit broken);
    logic [7:0] first;
    logic [7:0] second;
    first = 8'($urandom_range(0, 255));
    second = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : first;
    push_word({1'b1, dev_addr});
    body_q = {{1'b0, mdss_pkg::CMD_ADDR_SET}, {1'b0, first}, {1'b0, second}};
    emit_body(broken);
  endtask

  // Random words; a buffer read or a boot exit never starts here.
  task automatic send_noise();
    int n;
    logic [8:0] w;
    n = $urandom_range(1, 8);
    if ($urandom_range(0, 1)) push_word({1'b1, dev_addr});
    repeat (n) begin
      w = 9'($urandom_range(0, 511));
      if (w == {1'b0, mdss_pkg::CMD_BUF_READ} || w == {1'b0, mdss_pkg::CMD_BOOT_OUT}) begin
        w[8] = 1'b1;
      end
      push_word(w);
    end
  endtask

  task automatic random_traffic(input int target);
    int pick;
    int cnt;
    bit broken;
    while (words_queued < target) begin
      sync_to_model();
      pick = $urandom_range(0, 99);
      broken = ($urandom_range(0, 9) == 0);
      if (pick < 30) begin
        cnt = $urandom_range(0, 99);
        if (cnt < 90) cnt = $urandom_range(0, 12);
        else if (cnt < 98) cnt = $urandom_range(13, 64);
        else cnt = $urandom_range(200, 255);
        send_write(cnt, broken);
      end else if (pick < 55) begin
        send_read(broken);
      end else if (pick < 67) begin
        send_id(broken);
      end else if (pick < 77) begin
        send_addr_set(broken);
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    load_address(8'hFF);
    for (int i = 0; i < DIRECTED_LEN; i++) push_word(DIRECTED_WORDS[i]);
    random_traffic(600);

    // A long write while the receiver holds off, so the slave backs up its input.
    load_address(8'h00);
    sync_to_model();
    send_write(60, 1'b0);
    hold_req = 1'b1;
    random_traffic(1200);

    load_address(8'($urandom_range(1, 254)));
    random_traffic(1850);

    // Boot exit halts the slave; everything after it is ignored.
    sync_to_model();
    push_word({1'b1, dev_addr});
    push_word({1'b0, mdss_pkg::CMD_BOOT_OUT});
    repeat (6) push_word(9'($urandom_range(0, 511)));
    settle();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[multidrop_serial_slave_unit.f]
hdl/mdss_pkg.sv
hdl/mdss_addr_fold.sv
hdl/multidrop_serial_slave_unit.sv
tb/multidrop_serial_slave_unit_tb.sv
